// ===== hdl/bounded_deque_core_macros.svh =====
// Assertion macros shared by the deque RTL.
`ifndef BOUNDED_DEQUE_CORE_MACROS_SVH
`define BOUNDED_DEQUE_CORE_MACROS_SVH

// Same-cycle implication, sampled on aclk and disabled during reset.
`define BDQ_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("deque assertion failed");

// Next-cycle implication, sampled on aclk and disabled during reset.
`define BDQ_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("deque assertion failed");

`endif

// ===== hdl/bdq_pkg.sv =====
// Types and codes shared by the deque cells and the deque top level.
package bdq_pkg;

    localparam int DEPTH    = 16;
    localparam int WORD_W   = 32;
    localparam int REQ_W    = 3;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = $clog2(DEPTH + 1);

    localparam logic [REQ_W-1:0] REQ_PUSH_FRONT = 3'd0;
    localparam logic [REQ_W-1:0] REQ_PUSH_BACK  = 3'd1;
    localparam logic [REQ_W-1:0] REQ_POP_FRONT  = 3'd2;
    localparam logic [REQ_W-1:0] REQ_POP_BACK   = 3'd3;
    localparam logic [REQ_W-1:0] REQ_PEEK_FRONT = 3'd4;
    localparam logic [REQ_W-1:0] REQ_PEEK_BACK  = 3'd5;
    localparam logic [REQ_W-1:0] REQ_CLEAR      = 3'd6;

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

    typedef struct packed {
        logic [REQ_W-1:0]         req_type;
        logic signed [WORD_W-1:0] push_value;
    } req_t;

    typedef struct packed {
        logic signed [WORD_W-1:0] read_value;
        logic [STATUS_W-1:0]      status;
        logic [COUNT_W-1:0]       entry_count;
    } rsp_t;

    // Per-cycle command broadcast to every cell of the chain.
    typedef struct packed {
        logic shift_in;   // push front: every word moves one cell toward the back
        logic shift_out;  // pop front: every word moves one cell toward the front
        logic load_back;  // push back: the cell just past the back word takes the value
    } cell_ctl_t;

endpackage

// ===== hdl/bdq_cell.sv =====
// One storage cell of the deque chain; position 0 holds the front word.
module bdq_cell
    import bdq_pkg::*;
#(
    parameter int INDEX = 0,
    parameter int CNT_W = 5
) (
    input  logic                     aclk,
    input  cell_ctl_t                ctl,
    input  logic [CNT_W-1:0]         count,
    input  logic signed [WORD_W-1:0] push_value,
    input  logic signed [WORD_W-1:0] left_data,
    input  logic signed [WORD_W-1:0] right_data,
    output logic signed [WORD_W-1:0] data_out,
    output logic signed [WORD_W-1:0] back_tap
);

    localparam logic [CNT_W-1:0] IDX      = CNT_W'(INDEX);
    localparam logic [CNT_W-1:0] IDX_NEXT = CNT_W'(INDEX + 1);

    logic signed [WORD_W-1:0] data_reg;
    logic signed [WORD_W-1:0] data_next;
    logic                     is_back;

    assign is_back = (count == IDX_NEXT);

    always_comb begin
        data_next = data_reg;
        if (ctl.shift_in) begin
            data_next = left_data;
        end else if (ctl.shift_out) begin
            data_next = right_data;
        end else if (ctl.load_back && (count == IDX)) begin
            data_next = push_value;
        end
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
    end

    assign data_out = data_reg;
    assign back_tap = is_back ? data_reg : '0;

endmodule

// ===== hdl/bounded_deque_core.sv =====
// Top level of the bounded double-ended queue built from a chain of cells.
//
// Requests arrive on the s_ channel (s_valid, s_ready, s_req) and each one
// produces exactly one result transaction on the m_ channel (m_valid,
// m_ready, m_rsp) carrying the word read, a status and the count afterwards.
// Words sit in a row of DEPTH cells with the front word in cell 0; a push
// or pop at the front shifts the whole row by one cell at once,
// a push at the back loads the cell just past the back word, and the back
// word is picked out of the row by a one-hot select.
// An accepted request's result is registered and shows in the cycle after
// acceptance. Throughput is one request per cycle while m_ready holds high,
// set by the single result register; the next request is taken in the cycle
// its predecessor's result leaves. When the receiver stalls, the result holds
// in m_rsp and s_ready stays low until it is taken.
// Reset (aresetn low, synchronous) empties the queue and drops any pending
// result; cell contents are not cleared since they are only read after a
// push writes them.
module bounded_deque_core
    import bdq_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic s_valid,
    output logic s_ready,
    input  req_t s_req,
    output logic m_valid,
    input  logic m_ready,
    output rsp_t m_rsp
);

    `include "bounded_deque_core_macros.svh"

    localparam int CNT_W = COUNT_W;
    localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(DEPTH);

    logic [CNT_W-1:0]         count_reg;
    logic [CNT_W-1:0]         count_next;
    logic                     m_valid_reg;
    rsp_t                     rsp_reg;
    rsp_t                     rsp_next;
    logic                     s_fire;
    logic                     is_full;
    logic                     is_empty;
    cell_ctl_t                ctl;
    logic signed [WORD_W-1:0] front_word;
    logic signed [WORD_W-1:0] back_word;

    logic signed [WORD_W-1:0] cell_data [DEPTH];
    logic signed [WORD_W-1:0] cell_tap  [DEPTH];

    assign s_ready  = !m_valid_reg || m_ready;
    assign s_fire   = s_valid && s_ready;
    assign is_full  = (count_reg == FULL_COUNT);
    assign is_empty = (count_reg == '0);

    genvar g;
    generate
        for (g = 0; g < DEPTH; g++) begin : g_cell
            logic signed [WORD_W-1:0] left_in;
            logic signed [WORD_W-1:0] right_in;
            if (g == 0) begin : g_first
                assign left_in = s_req.push_value;
            end else begin : g_mid
                assign left_in = cell_data[g-1];
            end
            if (g == DEPTH - 1) begin : g_last
                assign right_in = cell_data[g];
            end else begin : g_inner
                assign right_in = cell_data[g+1];
            end
            bdq_cell #(
                .INDEX(g),
                .CNT_W(CNT_W)
            ) u_cell (
                .aclk      (aclk),
                .ctl       (ctl),
                .count     (count_reg),
                .push_value(s_req.push_value),
                .left_data (left_in),
                .right_data(right_in),
                .data_out  (cell_data[g]),
                .back_tap  (cell_tap[g])
            );
        end
    endgenerate

    assign front_word = cell_data[0];

    // Only the cell holding the back word drives a nonzero tap.
    always_comb begin
        back_word = '0;
        for (int i = 0; i < DEPTH; i++) begin
            back_word = back_word | cell_tap[i];
        end
    end

    always_comb begin
        ctl                 = '0;
        count_next          = count_reg;
        rsp_next.read_value = '0;
        rsp_next.status     = ST_OK;
        unique case (s_req.req_type)
            REQ_PUSH_FRONT: begin
                if (is_full) begin
                    rsp_next.status = ST_FULL;
                end else begin
                    ctl.shift_in = s_fire;
                    count_next   = count_reg + 1'b1;
                end
            end
            REQ_PUSH_BACK: begin
                if (is_full) begin
                    rsp_next.status = ST_FULL;
                end else begin
                    ctl.load_back = s_fire;
                    count_next    = count_reg + 1'b1;
                end
            end
            REQ_POP_FRONT, REQ_PEEK_FRONT: begin
                if (is_empty) begin
                    rsp_next.status = ST_EMPTY;
                end else begin
                    rsp_next.read_value = front_word;
                    if (s_req.req_type == REQ_POP_FRONT) begin
                        ctl.shift_out = s_fire;
                        count_next    = count_reg - 1'b1;
                    end
                end
            end
            REQ_POP_BACK, REQ_PEEK_BACK: begin
                if (is_empty) begin
                    rsp_next.status = ST_EMPTY;
                end else begin
                    rsp_next.read_value = back_word;
                    if (s_req.req_type == REQ_POP_BACK) begin
                        count_next = count_reg - 1'b1;
                    end
                end
            end
            REQ_CLEAR: begin
                count_next = '0;
            end
            default: begin
                // The unused code leaves the queue untouched.
            end
        endcase
        rsp_next.entry_count = COUNT_W'(count_next);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (s_fire) begin
                count_reg <= count_next;
            end
            if (s_fire) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            rsp_reg <= rsp_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_rsp   = rsp_reg;

    `BDQ_ASSERT_NOW(a_count_bounded, 1'b1, count_reg <= FULL_COUNT)
    `BDQ_ASSERT_NOW(a_full_result_count, m_valid_reg && (rsp_reg.status == ST_FULL), is_full)
    `BDQ_ASSERT_NEXT(a_clear_empties, s_fire && (s_req.req_type == REQ_CLEAR), is_empty)
    `BDQ_ASSERT_NEXT(a_push_back_grows,
        s_fire && (s_req.req_type == REQ_PUSH_BACK) && !is_full,
        count_reg == $past(count_reg) + 1'b1)

endmodule

// ===== bench/testbench.sv =====
// Self-checking testbench for the bounded double-ended queue core.
`timescale 1ns / 100ps

module testbench
    import bdq_pkg::*;
;

    localparam int QUEUE_DEPTH    = DEPTH;
    localparam int RESET_CYCLES   = 9;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 4;
    localparam int MAX_REPORTS    = 60;
    localparam int CHUNK_ITEMS    = 30;
    localparam int PHASE_CHUNKS   = 7;
    localparam int HOLD_OFF_LEN   = 48;

    // The package names codes zero to six; code seven is unused and ignored.
    localparam logic [REQ_W-1:0] REQ_UNUSED = 3'd7;

    localparam logic signed [WORD_W-1:0] WORD_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [WORD_W-1:0] WORD_MIN = 32'sh8000_0000;

    // Tracks the deque contents and checks each result against its prediction.
    class deque_scoreboard;
        logic signed [WORD_W-1:0] ring [QUEUE_DEPTH];
        int unsigned              front_idx;
        int unsigned              back_idx;
        logic [COUNT_W-1:0]       stored;
        rsp_t                     expected_q [$];
        int unsigned              error_count;

        function new();
            front_idx   = 0;
            back_idx    = 0;
            stored      = '0;
            error_count = 0;
        endfunction

        function void flag_error(input string msg);
            error_count++;
            if (error_count <= MAX_REPORTS) begin
                $display("%0t: %s", $time, msg);
            end
        endfunction

        function void note_request(input req_t r);
            rsp_t        e;
            int unsigned slot;
            e.read_value = '0;
            e.status     = ST_OK;
            case (r.req_type)
                REQ_PUSH_FRONT, REQ_PUSH_BACK: begin
                    if (stored >= QUEUE_DEPTH) begin
                        e.status = ST_FULL;
                    end else if (r.req_type == REQ_PUSH_FRONT) begin
                        front_idx = (front_idx == 0) ? QUEUE_DEPTH - 1 : front_idx - 1;
                        ring[front_idx] = r.push_value;
                        stored = stored + 1'b1;
                    end else begin
                        ring[back_idx] = r.push_value;
                        back_idx = (back_idx + 1) % QUEUE_DEPTH;
                        stored = stored + 1'b1;
                    end
                end
                REQ_POP_FRONT, REQ_PEEK_FRONT: begin
                    if (stored == 0) begin
                        e.status = ST_EMPTY;
                    end else begin
                        e.read_value = ring[front_idx];
                        if (r.req_type == REQ_POP_FRONT) begin
                            front_idx = (front_idx + 1) % QUEUE_DEPTH;
                            stored = stored - 1'b1;
                        end
                    end
                end
                REQ_POP_BACK, REQ_PEEK_BACK: begin
                    if (stored == 0) begin
                        e.status = ST_EMPTY;
                    end else begin
                        slot = (back_idx == 0) ? QUEUE_DEPTH - 1 : back_idx - 1;
                        e.read_value = ring[slot];
                        if (r.req_type == REQ_POP_BACK) begin
                            back_idx = slot;
                            stored = stored - 1'b1;
                        end
                    end
                end
                REQ_CLEAR: begin
                    front_idx = 0;
                    back_idx  = 0;
                    stored    = '0;
                end
                default: begin
                end
            endcase
            e.entry_count = stored;
            expected_q.insert(expected_q.size(), e);
        endfunction

        function void check_response(input rsp_t got);
            rsp_t e;
            if (expected_q.size() == 0) begin
                flag_error($sformatf("unexpected result transaction: value %0d status %0d count %0d",
                                     got.read_value, got.status, got.entry_count));
                return;
            end
            e = expected_q[0];
            expected_q.delete(0);
            if (got.read_value !== e.read_value) begin
                flag_error($sformatf("read_value expected %0d, got %0d",
                                     e.read_value, got.read_value));
            end
            if (got.status !== e.status) begin
                flag_error($sformatf("status expected %0d, got %0d", e.status, got.status));
            end
            if (got.entry_count !== e.entry_count) begin
                flag_error($sformatf("entry_count expected %0d, got %0d",
                                     e.entry_count, got.entry_count));
            end
        endfunction

        function int unsigned pending();
            return expected_q.size();
        endfunction
    endclass

    logic aclk;
    logic aresetn;
    logic s_valid;
    logic s_ready;
    req_t s_req;
    logic m_valid;
    logic m_ready;
    rsp_t m_rsp;

    int unsigned sender_idle_pct;
    int unsigned stall_pct;
    int unsigned hold_off_request;
    int unsigned quiet_cycles;

    deque_scoreboard sb;

    bounded_deque_core dut (
        .aclk   (aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_req  (s_req),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_rsp  (m_rsp)
    );

    initial begin
        aclk = 1'b0;
    end

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Result channel: random stalls, plus long hold-offs requested by the sender side.
    initial begin : receiver
        int unsigned hold_left;
        hold_left = 0;
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_off_request != 0) begin
                hold_left = hold_off_request;
                hold_off_request = 0;
            end
            if (hold_left != 0) begin
                m_ready <= 1'b0;
                hold_left--;
            end else begin
                m_ready <= ($urandom_range(99) >= stall_pct);
            end
        end
    end

    // Observe both channels; the watchdog ends the run if traffic stops.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready) begin
                sb.check_response(m_rsp);
            end
            if (s_valid && s_ready) begin
                sb.note_request(s_req);
            end
            if ((m_valid && m_ready) || (s_valid && s_ready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("%0t: no transaction for %0d cycles", $time, quiet_cycles);
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    task automatic send_request(input req_t r);
        while ($urandom_range(99) < sender_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_req   <= r;
        do begin
            @(posedge aclk);
        end while (!s_ready);
        @(negedge aclk);
    endtask

    task automatic send_op(input logic [REQ_W-1:0] op, input logic signed [WORD_W-1:0] value);
        req_t r;
        r.req_type   = op;
        r.push_value = value;
        send_request(r);
    endtask

    // Sender stays quiet until every predicted result has come back.
    task automatic wait_for_drain();
        s_valid <= 1'b0;
        @(negedge aclk);
        while (sb.pending() != 0) begin
            @(negedge aclk);
        end
    endtask

    function automatic req_t random_request(input int unsigned push_pct,
                                            input int unsigned pop_pct);
        req_t        r;
        int unsigned pick;
        pick = $urandom_range(99);
        if (pick < push_pct) begin
            r.req_type = $urandom_range(1) ? REQ_PUSH_BACK : REQ_PUSH_FRONT;
        end else if (pick < push_pct + pop_pct) begin
            r.req_type = $urandom_range(1) ? REQ_POP_BACK : REQ_POP_FRONT;
        end else if (pick < 96) begin
            r.req_type = $urandom_range(1) ? REQ_PEEK_BACK : REQ_PEEK_FRONT;
        end else if (pick < 98) begin
            r.req_type = REQ_CLEAR;
        end else begin
            r.req_type = REQ_UNUSED;
        end
        case ($urandom_range(15))
            0:       r.push_value = WORD_MAX;
            1:       r.push_value = WORD_MIN;
            2:       r.push_value = '0;
            3:       r.push_value = -1;
            default: r.push_value = $urandom;
        endcase
        return r;
    endfunction

    // Chunks cycle through filling, mixed and draining traffic so that
    // both the full and the empty boundaries are hit repeatedly.
    task automatic run_phase(input int unsigned idle_pct, input int unsigned stall);
        int unsigned push_pct;
        int unsigned pop_pct;
        sender_idle_pct = idle_pct;
        stall_pct       = stall;
        for (int c = 0; c < PHASE_CHUNKS; c++) begin
            case (c % 4)
                0:       begin push_pct = 80; pop_pct = 10; end
                2:       begin push_pct = 15; pop_pct = 70; end
                default: begin push_pct = 45; pop_pct = 40; end
            endcase
            for (int i = 0; i < CHUNK_ITEMS; i++) begin
                send_request(random_request(push_pct, pop_pct));
            end
        end
        wait_for_drain();
    endtask

    initial begin
        sb               = new();
        aresetn          = 1'b0;
        s_valid          = 1'b0;
        s_req            = '0;
        sender_idle_pct  = 0;
        stall_pct        = 0;
        hold_off_request = 0;
        quiet_cycles     = 0;
        repeat (RESET_CYCLES) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Empty queue: pops and peeks report empty, the unused code and clear change nothing.
        send_op(REQ_POP_FRONT, WORD_MAX);
        send_op(REQ_POP_BACK, WORD_MIN);
        send_op(REQ_PEEK_FRONT, -1);
        send_op(REQ_PEEK_BACK, '0);
        send_op(REQ_UNUSED, -1);
        send_op(REQ_CLEAR, WORD_MAX);
        // Extreme words at both ends, wrapping the front index below zero.
        send_op(REQ_PUSH_FRONT, WORD_MAX);
        send_op(REQ_PUSH_BACK, WORD_MIN);
        send_op(REQ_PUSH_FRONT, -1);
        send_op(REQ_PUSH_BACK, '0);
        send_op(REQ_PEEK_FRONT, '0);
        send_op(REQ_PEEK_BACK, -1);
        send_op(REQ_UNUSED, 32'shAAAA_AAAA);
        send_op(REQ_POP_BACK, '0);
        send_op(REQ_POP_FRONT, '0);
        send_op(REQ_POP_FRONT, '0);
        send_op(REQ_POP_BACK, '0);
        send_op(REQ_POP_FRONT, '0);
        // Clear with words stored, then confirm they are unreachable.
        send_op(REQ_PUSH_BACK, 32'sh5555_5555);
        send_op(REQ_PUSH_FRONT, 32'shAAAA_AAAA);
        send_op(REQ_CLEAR, '0);
        send_op(REQ_PEEK_BACK, '0);
        wait_for_drain();

        // Receiver holds off while the sender keeps offering, so the input stalls.
        hold_off_request = HOLD_OFF_LEN;
        for (int i = 0; i < 10; i++) begin
            send_request(random_request(80, 10));
        end
        wait_for_drain();

        run_phase(0, 0);
        run_phase(74, 0);
        run_phase(0, 74);
        run_phase(27, 27);

        repeat (DRAIN_CYCLES) @(negedge aclk);
        if (sb.error_count == 0 && sb.pending() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+hdl
hdl/bdq_pkg.sv
hdl/bdq_cell.sv
hdl/bounded_deque_core.sv
bench/testbench.sv
